// File: design/ascii_hex_motor_servo_command_decoder_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the motor/servo command decoder
// Shared property templates. Each use sits on a line of its own.
// ---------------------------------------------------------------------------
`ifndef ASCII_HEX_MOTOR_SERVO_COMMAND_DECODER_DEFINES_SVH
`define ASCII_HEX_MOTOR_SERVO_COMMAND_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define AHMSD_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define AHMSD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: design/ahmsd_pkg.sv
// ---------------------------------------------------------------------------
// ahmsd_pkg
// Types and constants shared by the command decoder front, queue and back.
// ---------------------------------------------------------------------------
package ahmsd_pkg;

	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_ONE    = 8'h31;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UA     = 8'h41;
	localparam logic [7:0] CHAR_UF     = 8'h46;
	// 'A' - 10, so that 'A' maps to digit 10
	localparam logic [7:0] CHAR_UA_M10 = 8'h37;

	localparam logic [5:0] LAST_POS_KIND0 = 6'd32;
	localparam logic [5:0] LAST_POS_KIND1 = 6'd8;

	localparam logic [11:0] MOTOR_LIMIT = 12'd1000;
	localparam logic [11:0] SERVO_LIMIT = 12'd180;
	localparam logic [11:0] PULSE_BASE  = 12'd500;

	// floor(a*2000/180) = floor(a*100*29128 / 2^18) for a <= 180
	localparam int          PULSE_SHIFT = 18;
	localparam logic [29:0] PULSE_RECIP = 30'd2912800;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic       store_en;
		logic       emit;
		logic       is_servo;
		logic [1:0] slot;
		logic       reverse;
		logic [9:0] duty;
		logic [7:0] angle;
	} cmd_t;

	typedef struct packed {
		logic [3:0]       reverse;
		logic [3:0][9:0]  duty;
		logic [3:0][11:0] pulse;
	} res_t;

endpackage

// File: design/ahmsd_front.sv
// ---------------------------------------------------------------------------
// ahmsd_front
// Frame parser: tracks byte position, assembles sign and hex digits into a
// field, clamps it and issues store/emit commands to the queue.
// ---------------------------------------------------------------------------
`include "ascii_hex_motor_servo_command_decoder_defines.svh"

module ahmsd_front import ahmsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	input  logic       accept,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic [5:0]  pos_q, pos_d;
	logic        kind_q, kind_d;
	logic        active_q, active_d;
	logic        neg_q, neg_d;
	logic [11:0] mag_q, mag_d;

	logic [5:0]  pos_m1;
	logic [1:0]  offset;
	logic [2:0]  field;
	logic [3:0]  digit;
	logic [11:0] mag_cat;
	logic [5:0]  last_pos;

	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			t = c - CHAR_ZERO;
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			t = c - CHAR_UA_M10;
		end
		return t[3:0];
	endfunction

	always_comb begin
		pos_d    = pos_q;
		kind_d   = kind_q;
		active_d = active_q;
		neg_d    = neg_q;
		mag_d    = mag_q;
		cmd      = '0;
		cmd_push = 1'b0;

		pos_m1   = pos_q - 6'd1;
		offset   = pos_m1[1:0];
		field    = pos_m1[4:2];
		digit    = hex_digit(rx_byte);
		mag_cat  = {mag_q[7:0], digit};
		last_pos = kind_q ? LAST_POS_KIND1 : LAST_POS_KIND0;

		cmd.is_servo = !kind_q && field[2];
		cmd.slot     = kind_q ? ((field == 3'd0) ? 2'd1 : 2'd0) : field[1:0];
		cmd.reverse  = neg_q || (mag_cat == 12'd0);
		cmd.duty     = (mag_cat > MOTOR_LIMIT) ? MOTOR_LIMIT[9:0] : mag_cat[9:0];
		if (neg_q) begin
			cmd.angle = 8'd0;
		end else begin
			cmd.angle = (mag_cat > SERVO_LIMIT) ? SERVO_LIMIT[7:0] : mag_cat[7:0];
		end

		if (accept) begin
			if (frame_start) begin
				pos_d  = 6'd1;
				neg_d  = 1'b0;
				mag_d  = 12'd0;
				active_d = (rx_byte == CHAR_ZERO) || (rx_byte == CHAR_ONE);
				if (rx_byte == CHAR_ZERO) begin
					kind_d = 1'b0;
				end else if (rx_byte == CHAR_ONE) begin
					kind_d = 1'b1;
				end
			end else if (active_q) begin
				if (offset == 2'd0) begin
					neg_d = (rx_byte == CHAR_MINUS);
					mag_d = 12'd0;
				end else begin
					mag_d = mag_cat;
				end
				cmd.store_en = (offset == 2'd3);
				cmd.emit     = (pos_q >= last_pos);
				cmd_push     = cmd.store_en || cmd.emit;
				if (cmd.emit) begin
					active_d = 1'b0;
					pos_d    = 6'd0;
				end else begin
					pos_d = pos_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 6'd0;
			kind_q   <= 1'b0;
			active_q <= 1'b0;
			neg_q    <= 1'b0;
			mag_q    <= 12'd0;
		end else begin
			pos_q    <= pos_d;
			kind_q   <= kind_d;
			active_q <= active_d;
			neg_q    <= neg_d;
			mag_q    <= mag_d;
		end
	end

	`AHMSD_ASSERT_IMPL(a_motor_duty_clamped, clk, arst_n, cmd_push && cmd.store_en && !cmd.is_servo, cmd.duty <= MOTOR_LIMIT[9:0], "motor duty above limit")
	`AHMSD_ASSERT_IMPL(a_servo_angle_clamped, clk, arst_n, cmd_push && cmd.store_en && cmd.is_servo, cmd.angle <= SERVO_LIMIT[7:0], "servo angle above limit")
	`AHMSD_ASSERT_NEXT(a_emit_closes_frame, clk, arst_n, cmd_push && cmd.emit, !active_q && pos_q == 6'd0, "frame still open after emit")

endmodule

// File: design/ahmsd_cmd_queue.sv
// ---------------------------------------------------------------------------
// ahmsd_cmd_queue
// Short command queue between parser and executor; decouples their stalls.
// ---------------------------------------------------------------------------
`include "ascii_hex_motor_servo_command_decoder_defines.svh"

module ahmsd_cmd_queue import ahmsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_data
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`AHMSD_ASSERT_NEXT(a_fill_tracks_write, clk, arst_n, wr_en && !rd_en, cnt_q == $past(cnt_q) + QCNT_W'(1), "queue count lost a write")

endmodule

// File: design/ahmsd_back.sv
// ---------------------------------------------------------------------------
// ahmsd_back
// Executor: applies stores to the held motor and servo values and captures
// a result snapshot into the output register on emit.
// ---------------------------------------------------------------------------
`include "ascii_hex_motor_servo_command_decoder_defines.svh"

module ahmsd_back import ahmsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_take,
	input  logic res_pop,
	output logic res_valid,
	output res_t res
);

	logic [3:0]       rev_q, rev_d;
	logic [3:0][9:0]  duty_q, duty_d;
	logic [3:0][11:0] pulse_q, pulse_d;
	logic             out_valid_q;
	res_t             res_q;

	logic [29:0] prod;
	logic [11:0] pulse_new;

	// hold an emit while the output register still waits for a transfer
	assign cmd_take  = cmd_valid && (!cmd.emit || !out_valid_q || res_pop);
	assign res_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		rev_d     = rev_q;
		duty_d    = duty_q;
		pulse_d   = pulse_q;
		prod      = {22'd0, cmd.angle} * PULSE_RECIP;
		pulse_new = prod[29:PULSE_SHIFT] + PULSE_BASE;
		if (cmd_take && cmd.store_en) begin
			if (cmd.is_servo) begin
				pulse_d[cmd.slot] = pulse_new;
			end else begin
				rev_d[cmd.slot]  = cmd.reverse;
				duty_d[cmd.slot] = cmd.duty;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q       <= '1;
			duty_q      <= '0;
			pulse_q     <= {4{PULSE_BASE}};
			out_valid_q <= 1'b0;
		end else begin
			rev_q   <= rev_d;
			duty_q  <= duty_d;
			pulse_q <= pulse_d;
			if (cmd_take && cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (res_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.emit) begin
			res_q.reverse <= rev_d;
			res_q.duty    <= duty_d;
			res_q.pulse   <= pulse_d;
		end
	end

	`AHMSD_ASSERT_NEXT(a_emit_sets_valid, clk, arst_n, cmd_take && cmd.emit, out_valid_q, "emit did not load result")
	`AHMSD_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd_take && cmd.emit && out_valid_q, res_pop, "result overwritten before transfer")

endmodule

// File: design/ascii_hex_motor_servo_command_decoder.sv
// ---------------------------------------------------------------------------
// ascii_hex_motor_servo_command_decoder
// ASCII hex command frame decoder for four motors and four servos.
// ---------------------------------------------------------------------------
// channel   handshake          payload
// input     push / full        rx_byte, frame_start
// result    empty / pop        motorN_reverse, motorN_duty, servoN_pulse
//
// One byte is taken every cycle while full is low; the parser has no iteration.
// A result shows on the ports from the executor's output register: the
// command queue takes the command at the edge that transfers the frame's
// last byte, then the executor loads its output register from the queue
// head unless a waiting result stalls it (servo pulse multiply sits there).
// Reset: parser idle, motors reverse 1 / duty 0, servo pulses 500.
// A waiting result stalls the next emit command in the two-entry queue;
// full rises once that queue holds two commands.
// ---------------------------------------------------------------------------
module ascii_hex_motor_servo_command_decoder import ahmsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        empty,
	input  logic        pop,
	output logic        motor1_reverse,
	output logic [9:0]  motor1_duty,
	output logic        motor2_reverse,
	output logic [9:0]  motor2_duty,
	output logic        motor3_reverse,
	output logic [9:0]  motor3_duty,
	output logic        motor4_reverse,
	output logic [9:0]  motor4_duty,
	output logic [11:0] servo1_pulse,
	output logic [11:0] servo2_pulse,
	output logic [11:0] servo3_pulse,
	output logic [11:0] servo4_pulse
);

	logic accept;
	logic cmd_push;
	cmd_t cmd_in;
	logic q_full;
	logic q_valid;
	cmd_t q_head;
	logic q_take;
	logic res_valid;
	res_t res;

	assign accept = push && !q_full;
	assign full   = q_full;
	assign empty  = !res_valid;

	ahmsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.accept      (accept),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	ahmsd_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (cmd_in),
		.full     (q_full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_head)
	);

	ahmsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_head),
		.cmd_take  (q_take),
		.res_pop   (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign motor1_reverse = res.reverse[0];
	assign motor2_reverse = res.reverse[1];
	assign motor3_reverse = res.reverse[2];
	assign motor4_reverse = res.reverse[3];
	assign motor1_duty    = res.duty[0];
	assign motor2_duty    = res.duty[1];
	assign motor3_duty    = res.duty[2];
	assign motor4_duty    = res.duty[3];
	assign servo1_pulse   = res.pulse[0];
	assign servo2_pulse   = res.pulse[1];
	assign servo3_pulse   = res.pulse[2];
	assign servo4_pulse   = res.pulse[3];

endmodule

// File: test/servo_motor_frame_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// servo_motor_frame_checker
// Rebuilds the motor and servo settings from every byte the decoder accepts,
// queues one expected setting per completed frame and compares each result
// transfer against the oldest one, field by field.
// ---------------------------------------------------------------------------
module servo_motor_frame_checker import ahmsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	input  logic        empty,
	input  logic        pop,
	input  logic        motor1_reverse,
	input  logic [9:0]  motor1_duty,
	input  logic        motor2_reverse,
	input  logic [9:0]  motor2_duty,
	input  logic        motor3_reverse,
	input  logic [9:0]  motor3_duty,
	input  logic        motor4_reverse,
	input  logic [9:0]  motor4_duty,
	input  logic [11:0] servo1_pulse,
	input  logic [11:0] servo2_pulse,
	input  logic [11:0] servo3_pulse,
	input  logic [11:0] servo4_pulse,
	output int          error_count,
	output int          pending
);

	typedef struct packed {
		logic [3:0]       reverse;
		logic [3:0][9:0]  duty;
		logic [3:0][11:0] pulse;
	} drive_setting_t;

	drive_setting_t settings_q[$];

	logic [5:0]  char_pos;
	logic        kind_one;
	logic        in_frame;
	logic        field_neg;
	logic [11:0] field_mag;
	int          motor_speed[4];
	int          servo_angle[4];

	initial begin
		error_count = 0;
		pending = 0;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t checker: %s", $time, msg);
		error_count++;
	endtask

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	// advance the frame parser by one accepted byte
	task automatic decode_frame_char(input logic [7:0] c, input logic st);
		logic [1:0]     offset;
		logic [2:0]     slot;
		logic [3:0]     digit;
		logic [5:0]     last_pos;
		int             value;
		int             lim;
		drive_setting_t want;
		if (st) begin
			char_pos = 6'd1;
			field_neg = 1'b0;
			field_mag = 12'd0;
			if (c == CHAR_ZERO) begin
				kind_one = 1'b0;
				in_frame = 1'b1;
			end else if (c == CHAR_ONE) begin
				kind_one = 1'b1;
				in_frame = 1'b1;
			end else begin
				in_frame = 1'b0;
			end
		end else if (in_frame) begin
			offset = 2'(char_pos - 6'd1);
			if (offset == 2'd0) begin
				field_neg = (c == CHAR_MINUS);
				field_mag = 12'd0;
			end else begin
				if (c >= CHAR_ZERO && c <= CHAR_NINE)
					digit = 4'(c - CHAR_ZERO);
				else if (c >= CHAR_UA && c <= CHAR_UF)
					digit = 4'(c - CHAR_UA_M10);
				else
					digit = 4'd0;
				field_mag = {field_mag[7:0], digit};
				if (offset == 2'd3) begin
					value = field_neg ? -int'(field_mag) : int'(field_mag);
					slot = 3'((char_pos - 6'd1) >> 2);
					lim = int'(MOTOR_LIMIT);
					if (kind_one)
						motor_speed[slot == 3'd0 ? 2'd1 : 2'd0] = clamp(value, -lim, lim);
					else if (slot < 3'd4)
						motor_speed[slot[1:0]] = clamp(value, -lim, lim);
					else
						servo_angle[slot[1:0]] = clamp(value, 0, int'(SERVO_LIMIT));
				end
			end
			last_pos = kind_one ? LAST_POS_KIND1 : LAST_POS_KIND0;
			if (char_pos >= last_pos) begin
				in_frame = 1'b0;
				char_pos = 6'd0;
				for (int i = 0; i < 4; i++) begin
					want.reverse[i] = !(motor_speed[i] > 0);
					want.duty[i] = 10'(motor_speed[i] < 0 ? -motor_speed[i] : motor_speed[i]);
					want.pulse[i] = 12'(servo_angle[i] * 2000 / 180 + int'(PULSE_BASE));
				end
				settings_q.push_back(want);
			end else begin
				char_pos = char_pos + 6'd1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		drive_setting_t got;
		drive_setting_t want;
		if (!arst_n) begin
			char_pos = 6'd0;
			kind_one = 1'b0;
			in_frame = 1'b0;
			field_neg = 1'b0;
			field_mag = 12'd0;
			for (int i = 0; i < 4; i++) begin
				motor_speed[i] = 0;
				servo_angle[i] = 0;
			end
			settings_q.delete();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				got.reverse = {motor4_reverse, motor3_reverse, motor2_reverse, motor1_reverse};
				got.duty = {motor4_duty, motor3_duty, motor2_duty, motor1_duty};
				got.pulse = {servo4_pulse, servo3_pulse, servo2_pulse, servo1_pulse};
				if (settings_q.size() == 0) begin
					flag_mismatch("result transfer with no completed frame outstanding");
				end else begin
					want = settings_q.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (got.reverse[i] !== want.reverse[i])
							flag_mismatch($sformatf("motor%0d reverse got %b want %b",
								i + 1, got.reverse[i], want.reverse[i]));
						if (got.duty[i] !== want.duty[i])
							flag_mismatch($sformatf("motor%0d duty got %0d want %0d",
								i + 1, got.duty[i], want.duty[i]));
						if (got.pulse[i] !== want.pulse[i])
							flag_mismatch($sformatf("servo%0d pulse got %0d want %0d",
								i + 1, got.pulse[i], want.pulse[i]));
					end
				end
			end
			if (push && !full)
				decode_frame_char(rx_byte, frame_start);
			pending <= settings_q.size();
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives command frames into the motor/servo decoder: a few hand-picked
// frames, then mostly well-formed random frames mixed with broken frames,
// unknown types and stray bytes, under varying idle rates on both sides.
// ---------------------------------------------------------------------------
module tb;
	import ahmsd_pkg::*;

	localparam int         CYCLE_LIMIT = 100000;
	localparam int         HOLD_CYCLES = 400;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'd0;
	logic        frame_start = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        motor1_reverse;
	logic [9:0]  motor1_duty;
	logic        motor2_reverse;
	logic [9:0]  motor2_duty;
	logic        motor3_reverse;
	logic [9:0]  motor3_duty;
	logic        motor4_reverse;
	logic [9:0]  motor4_duty;
	logic [11:0] servo1_pulse;
	logic [11:0] servo2_pulse;
	logic [11:0] servo3_pulse;
	logic [11:0] servo4_pulse;

	int error_count;
	int pending;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_req = 1'b0;
	int frame_chars = 0;
	int cycle_count = 0;

	ascii_hex_motor_servo_command_decoder u_top (.*);

	servo_motor_frame_checker u_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// result side: random pops, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// offer one byte and hold it until the transfer happens
	task automatic send_char(input logic [7:0] c, input logic st, input bit counts);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= c;
		frame_start <= st;
		do @(posedge clk); while (full);
		if (counts)
			frame_chars++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == 0, 1'b1);
	endtask

	task automatic send_field(input int span);
		int          pick;
		logic [7:0]  sign_c;
		logic [11:0] mag;
		logic [3:0]  nib;
		pick = $urandom_range(99);
		if (pick < 40)
			sign_c = CHAR_MINUS;
		else if (pick < 75)
			sign_c = CHAR_PLUS;
		else
			sign_c = 8'($urandom_range(255));
		pick = $urandom_range(9);
		if (pick == 0)
			mag = 12'd0;
		else if (pick == 1)
			mag = 12'(span);
		else if (pick == 2)
			mag = 12'hFFF;
		else if (pick < 6)
			mag = 12'($urandom_range(span));
		else
			mag = 12'($urandom);
		send_char(sign_c, 1'b0, 1'b1);
		for (int k = 2; k >= 0; k--) begin
			nib = mag[k*4 +: 4];
			if ($urandom_range(99) < 6)
				send_char(8'($urandom_range(255)), 1'b0, 1'b1);
			else
				send_char(nib < 4'd10 ? CHAR_ZERO + 8'(nib) : CHAR_UA_M10 + 8'(nib),
					1'b0, 1'b1);
		end
	endtask

	// a broken frame stops short and is abandoned by the next start
	task automatic send_frame(input bit kind_one, input bit broken);
		int fields;
		int stop_at;
		fields = kind_one ? 2 : 8;
		stop_at = broken ? $urandom_range(fields - 1) : fields;
		send_char(kind_one ? CHAR_ONE : CHAR_ZERO, 1'b1, 1'b1);
		for (int f = 0; f < stop_at; f++)
			send_field((!kind_one && f >= 4) ? int'(SERVO_LIMIT) : int'(MOTOR_LIMIT));
		if (broken)
			repeat ($urandom_range(3)) send_char(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic run_random(input int goal);
		int pick;
		frame_chars = 0;
		while (frame_chars < goal) begin
			pick = $urandom_range(99);
			if (pick < 84) begin
				send_frame($urandom_range(1), 1'b0);
			end else if (pick < 92) begin
				send_frame($urandom_range(1), 1'b1);
			end else if (pick < 96) begin
				send_char(8'($urandom_range(255)), 1'b1, 1'b0);
				repeat ($urandom_range(4)) send_char(8'($urandom_range(255)), 1'b0, 1'b0);
			end else begin
				send_char(8'($urandom_range(255)), 1'b0, 1'b0);
			end
		end
	endtask

	// drop push and wait for every completed frame to come out
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 38;
		recv_idle = 58;

		// stray byte, negative zero, clamps, non-minus sign, bad digits,
		// unknown type, abandoned frame
		send_char("F", 1'b0, 1'b1);
		send_text("1-000+3E9");
		send_text("1-FFFXa5G");
		send_text("7+");
		send_text("1+12");
		settle();

		hold_req = 1'b1;
		run_random(420);
		settle();

		send_idle = 58;
		recv_idle = 38;
		run_random(420);
		settle();

		send_idle = 0;
		recv_idle = 0;
		run_random(420);
		settle();

		repeat (20) @(posedge clk);
		if (error_count == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
